### sv/sdps_pkg.sv
// Shared constants and types for the shaded disc pixel shader.
package sdps_pkg;

   localparam int DEFAULT_MAX_DIM         = 4096;
   localparam int DEFAULT_COORD_FRAC_BITS = 8;

   localparam int PIXEL_W = 12;
   localparam int COORD_W = 24;
   localparam int SCALE_W = 16;
   localparam int DIM_W   = 13;
   localparam int COLOR_W = 8;
   localparam int INDEX_W = 24;

   // Scale registers are Q8.8.
   localparam int SCALE_FRAC = 8;

   // Fractional divide and square root step counts.
   localparam int DIV_STEPS = 32;
   localparam int SQ_STEPS  = 17;

   localparam logic [16:0] H_ONE = 17'h10000;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_X       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_Y       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 3'd5;

   localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd256;
   localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;

   // Data that rides alongside the arithmetic through every stage.
   typedef struct packed {
      logic                 live;
      logic [INDEX_W-1:0]   index;
      logic [3*COLOR_W-1:0] rim;
      logic [3*COLOR_W-1:0] core;
   } side_type;

   typedef struct packed {
      logic               write_enable;
      logic [INDEX_W-1:0] pixel_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } result_type;

endpackage

### sv/shaded_disc_pixel_shader_unit.sv
// Top level of the shaded disc pixel shader: a fully pipelined per-pixel disc shader.
//
// Each request transaction carries one candidate pixel and the disc it is tested against;
// each produces exactly one response transaction, in order. The block takes one transaction
// every clock while req_stall is low. Most of the pipeline stages belong to the 33-step
// restoring fractional divider (one quotient bit per stage) and to the 17-step integer
// square root (one result bit per stage), which together form
// h = sqrt(r^2 - d^2) / r. Between them every stage holds one subtract and compare, and the
// distance and radius squares use one 32 by 32 multiplier each in a stage of their own. The
// response port has an output register backed by a one-entry skid buffer, so the pipeline
// keeps accepting while a finished response waits; only when the skid entry is occupied does
// req_stall rise and the whole pipeline hold. Configuration registers must only be written
// while no transaction is in flight; csr_ready is always high.
module shaded_disc_pixel_shader_unit #(
   parameter int MAX_DIM         = sdps_pkg::DEFAULT_MAX_DIM,
   parameter int COORD_FRAC_BITS = sdps_pkg::DEFAULT_COORD_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [sdps_pkg::PIXEL_W-1:0]           req_pixel_x,
   input  logic [sdps_pkg::PIXEL_W-1:0]           req_pixel_y,
   input  logic signed [sdps_pkg::COORD_W-1:0]    req_center_x,
   input  logic signed [sdps_pkg::COORD_W-1:0]    req_center_y,
   input  logic [sdps_pkg::COORD_W-1:0]           req_radius,
   input  logic [sdps_pkg::COLOR_W-1:0]           req_rim_red,
   input  logic [sdps_pkg::COLOR_W-1:0]           req_rim_green,
   input  logic [sdps_pkg::COLOR_W-1:0]           req_rim_blue,
   input  logic [sdps_pkg::COLOR_W-1:0]           req_core_red,
   input  logic [sdps_pkg::COLOR_W-1:0]           req_core_green,
   input  logic [sdps_pkg::COLOR_W-1:0]           req_core_blue,
   // Response channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_write_enable,
   output logic [sdps_pkg::INDEX_W-1:0]           rsp_pixel_index,
   output logic [sdps_pkg::COLOR_W-1:0]           rsp_out_red,
   output logic [sdps_pkg::COLOR_W-1:0]           rsp_out_green,
   output logic [sdps_pkg::COLOR_W-1:0]           rsp_out_blue,
   // Configuration write channel.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sdps_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [sdps_pkg::COORD_W-1:0]           csr_data
);
   import sdps_pkg::*;

   localparam int F  = COORD_FRAC_BITS;
   // Pixel centre in fixed point.
   localparam int PW = PIXEL_W + F;
   // Mapped centre: 33-bit scaled term plus 24-bit offset.
   localparam int CW = 34;
   localparam int DW = ((PW + 1 > CW) ? PW + 1 : CW) + 1;
   localparam logic [31:0]   MAX_DIM_L = MAX_DIM;
   localparam logic [PW-1:0] HALF = {{(PW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

   // ------------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------------
   logic signed [COORD_W-1:0] offset_x_ff, offset_y_ff;
   logic [SCALE_W-1:0]        scale_x_ff, scale_y_ff;
   logic [DIM_W-1:0]          width_ff, height_ff;
   logic [DIM_W-1:0]          width_eff, height_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         scale_x_ff  <= SCALE_RESET;
         scale_y_ff  <= SCALE_RESET;
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OFFSET_X:      offset_x_ff <= $signed(csr_data);
            CSR_OFFSET_Y:      offset_y_ff <= $signed(csr_data);
            CSR_SCALE_X:       scale_x_ff  <= csr_data[SCALE_W-1:0];
            CSR_SCALE_Y:       scale_y_ff  <= csr_data[SCALE_W-1:0];
            CSR_SCREEN_WIDTH:  width_ff    <= csr_data[DIM_W-1:0];
            CSR_SCREEN_HEIGHT: height_ff   <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Raster dimensions above the maximum are clamped to it.
   assign width_eff  = ({19'd0, width_ff} > MAX_DIM_L)  ? MAX_DIM_L[DIM_W-1:0] : width_ff;
   assign height_eff = ({19'd0, height_ff} > MAX_DIM_L) ? MAX_DIM_L[DIM_W-1:0] : height_ff;

   // ------------------------------------------------------------------------
   // Pipeline control. Every stage moves together; the pipeline only holds when
   // the skid entry is occupied.
   // ------------------------------------------------------------------------
   logic pipe_en;
   logic out_valid_ff, skid_valid_ff;

   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ------------------------------------------------------------------------
   // Stage 1: world to screen products, pixel index and the on-screen test.
   // ------------------------------------------------------------------------
   logic signed [40:0] s1_prodx_in, s1_prody_in, s1_prodx_ff, s1_prody_ff;
   logic [39:0]        s1_prodr_in, s1_prodr_ff;
   logic [24:0]        s1_index_full;
   side_type           s1_side_in, s1_side_ff;
   logic [PIXEL_W-1:0] s1_px_ff, s1_py_ff;
   logic               s1_valid_ff;

   always_comb begin
      s1_prodx_in   = req_center_x * $signed({1'b0, scale_x_ff});
      s1_prody_in   = req_center_y * $signed({1'b0, scale_y_ff});
      s1_prodr_in   = 40'(req_radius) * 40'(scale_x_ff);
      s1_index_full = 25'(req_pixel_y) * 25'(width_eff) + 25'(req_pixel_x);
      s1_side_in.live  = ({1'b0, req_pixel_x} < width_eff) && ({1'b0, req_pixel_y} < height_eff);
      s1_side_in.index = s1_index_full[INDEX_W-1:0];
      s1_side_in.rim   = {req_rim_red, req_rim_green, req_rim_blue};
      s1_side_in.core  = {req_core_red, req_core_green, req_core_blue};
   end

   // ------------------------------------------------------------------------
   // Stage 2: mapped centre and radius, pixel centre.
   // ------------------------------------------------------------------------
   logic signed [CW-1:0] s2_cx_in, s2_cy_in, s2_cx_ff, s2_cy_ff;
   logic [PW-1:0]        s2_fx_in, s2_fy_in, s2_fx_ff, s2_fy_ff;
   logic [31:0]          s2_r_ff;
   side_type             s2_side_ff;
   logic                 s2_valid_ff;

   always_comb begin
      s2_cx_in = CW'(offset_x_ff) + CW'(s1_prodx_ff >>> SCALE_FRAC);
      s2_cy_in = CW'(offset_y_ff) + CW'(s1_prody_ff >>> SCALE_FRAC);
      s2_fx_in = {s1_px_ff, {F{1'b0}}} | HALF;
      s2_fy_in = {s1_py_ff, {F{1'b0}}} | HALF;
   end

   // Stage 3: signed offsets from the centre.
   logic signed [DW-1:0] s3_dx_in, s3_dy_in, s3_dx_ff, s3_dy_ff;
   logic [31:0]          s3_r_ff;
   side_type             s3_side_ff;
   logic                 s3_valid_ff;

   always_comb begin
      s3_dx_in = $signed({{(DW - PW){1'b0}}, s2_fx_ff}) - DW'(s2_cx_ff);
      s3_dy_in = $signed({{(DW - PW){1'b0}}, s2_fy_ff}) - DW'(s2_cy_ff);
   end

   // Stage 4: magnitudes.
   logic [DW-1:0] s4_adx_in, s4_ady_in, s4_adx_ff, s4_ady_ff;
   logic [31:0]   s4_r_ff;
   side_type      s4_side_ff;
   logic          s4_valid_ff;

   always_comb begin
      s4_adx_in = s3_dx_ff[DW-1] ? DW'(-s3_dx_ff) : DW'(s3_dx_ff);
      s4_ady_in = s3_dy_ff[DW-1] ? DW'(-s3_dy_ff) : DW'(s3_dy_ff);
   end

   // Stage 5: bounding square test and zero radius rejection; offsets now fit 32 bits.
   logic [31:0] s5_adx_ff, s5_ady_ff, s5_r_ff;
   side_type    s5_side_in, s5_side_ff;
   logic        s5_valid_ff;

   always_comb begin
      s5_side_in      = s4_side_ff;
      s5_side_in.live = s4_side_ff.live && (s4_r_ff != 32'd0)
                        && (s4_adx_ff <= {{(DW - 32){1'b0}}, s4_r_ff})
                        && (s4_ady_ff <= {{(DW - 32){1'b0}}, s4_r_ff});
   end

   // Stage 6: squares.
   logic [63:0] s6_r2_ff, s6_dx2_ff, s6_dy2_ff;
   side_type    s6_side_ff;
   logic        s6_valid_ff;

   // Stage 7: r^2 - dy^2.
   logic [63:0] s7_rem_ff, s7_dx2_ff, s7_r2_ff;
   side_type    s7_side_in, s7_side_ff;
   logic        s7_valid_ff;

   always_comb begin
      s7_side_in      = s6_side_ff;
      s7_side_in.live = s6_side_ff.live && (s6_dy2_ff <= s6_r2_ff);
   end

   // Stage 8: q = r^2 - dy^2 - dx^2.
   logic [63:0] s8_q_ff, s8_r2_ff;
   side_type    s8_side_in, s8_side_ff;
   logic        s8_valid_ff;

   always_comb begin
      s8_side_in      = s7_side_ff;
      s8_side_in.live = s7_side_ff.live && (s7_dx2_ff <= s7_rem_ff);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_prodx_ff <= s1_prodx_in;
         s1_prody_ff <= s1_prody_in;
         s1_prodr_ff <= s1_prodr_in;
         s1_side_ff  <= s1_side_in;
         s1_px_ff    <= req_pixel_x;
         s1_py_ff    <= req_pixel_y;

         s2_cx_ff   <= s2_cx_in;
         s2_cy_ff   <= s2_cy_in;
         s2_fx_ff   <= s2_fx_in;
         s2_fy_ff   <= s2_fy_in;
         s2_r_ff    <= s1_prodr_ff[39:8];
         s2_side_ff <= s1_side_ff;

         s3_dx_ff   <= s3_dx_in;
         s3_dy_ff   <= s3_dy_in;
         s3_r_ff    <= s2_r_ff;
         s3_side_ff <= s2_side_ff;

         s4_adx_ff  <= s4_adx_in;
         s4_ady_ff  <= s4_ady_in;
         s4_r_ff    <= s3_r_ff;
         s4_side_ff <= s3_side_ff;

         s5_adx_ff  <= s4_adx_ff[31:0];
         s5_ady_ff  <= s4_ady_ff[31:0];
         s5_r_ff    <= s4_r_ff;
         s5_side_ff <= s5_side_in;

         s6_r2_ff   <= 64'(s5_r_ff) * 64'(s5_r_ff);
         s6_dx2_ff  <= 64'(s5_adx_ff) * 64'(s5_adx_ff);
         s6_dy2_ff  <= 64'(s5_ady_ff) * 64'(s5_ady_ff);
         s6_side_ff <= s5_side_ff;

         s7_rem_ff  <= s6_r2_ff - s6_dy2_ff;
         s7_dx2_ff  <= s6_dx2_ff;
         s7_r2_ff   <= s6_r2_ff;
         s7_side_ff <= s7_side_in;

         s8_q_ff    <= s7_rem_ff - s7_dx2_ff;
         s8_r2_ff   <= s7_r2_ff;
         s8_side_ff <= s8_side_in;
      end
   end

   // ------------------------------------------------------------------------
   // Fractional divider: floor(q * 2^32 / r^2), one quotient bit per stage.
   // Entry 0 takes the integer bit, entries 1 to 32 the fraction bits.
   // ------------------------------------------------------------------------
   logic [63:0] div_rem_ff [0:DIV_STEPS];
   logic [32:0] div_quo_ff [0:DIV_STEPS];
   logic [63:0] div_d_ff   [0:DIV_STEPS];
   side_type    div_side_ff [0:DIV_STEPS];
   logic        div_valid_ff [0:DIV_STEPS];
   logic [63:0] div_rem_in [1:DIV_STEPS];
   logic [32:0] div_quo_in [1:DIV_STEPS];
   logic        div_first_ge;

   always_comb begin
      logic [64:0] wide;
      logic        ge;
      wide = '0;
      ge   = 1'b0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         wide = {div_rem_ff[k-1], 1'b0};
         ge   = wide >= {1'b0, div_d_ff[k-1]};
         div_rem_in[k] = ge ? 64'(wide - {1'b0, div_d_ff[k-1]}) : wide[63:0];
         div_quo_in[k] = {div_quo_ff[k-1][31:0], ge};
      end
   end

   assign div_first_ge = s8_q_ff >= s8_r2_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         div_rem_ff[0]  <= div_first_ge ? s8_q_ff - s8_r2_ff : s8_q_ff;
         div_quo_ff[0]  <= {32'd0, div_first_ge};
         div_d_ff[0]    <= s8_r2_ff;
         div_side_ff[0] <= s8_side_ff;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            div_rem_ff[k]  <= div_rem_in[k];
            div_quo_ff[k]  <= div_quo_in[k];
            div_d_ff[k]    <= div_d_ff[k-1];
            div_side_ff[k] <= div_side_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Integer square root of the quotient, one result bit per stage, starting
   // from the power of four 2^32.
   // ------------------------------------------------------------------------
   logic [33:0] sq_v_ff   [0:SQ_STEPS-1];
   logic [33:0] sq_res_ff [0:SQ_STEPS-1];
   side_type    sq_side_ff  [0:SQ_STEPS-1];
   logic        sq_valid_ff [0:SQ_STEPS-1];
   logic [33:0] sq_src_v   [0:SQ_STEPS-1];
   logic [33:0] sq_src_res [0:SQ_STEPS-1];
   side_type    sq_src_side [0:SQ_STEPS-1];
   logic [33:0] sq_v_in   [0:SQ_STEPS-1];
   logic [33:0] sq_res_in [0:SQ_STEPS-1];

   always_comb begin
      logic [33:0] bitv;
      logic [33:0] t;
      bitv = '0;
      t    = '0;
      sq_src_v[0]    = {1'b0, div_quo_ff[DIV_STEPS]};
      sq_src_res[0]  = '0;
      sq_src_side[0] = div_side_ff[DIV_STEPS];
      for (int j = 1; j < SQ_STEPS; j++) begin
         sq_src_v[j]    = sq_v_ff[j-1];
         sq_src_res[j]  = sq_res_ff[j-1];
         sq_src_side[j] = sq_side_ff[j-1];
      end
      for (int j = 0; j < SQ_STEPS; j++) begin
         bitv = 34'd1 << (2 * (SQ_STEPS - 1 - j));
         t    = sq_src_res[j] + bitv;
         if (sq_src_v[j] >= t) begin
            sq_v_in[j]   = sq_src_v[j] - t;
            sq_res_in[j] = (sq_src_res[j] >> 1) + bitv;
         end else begin
            sq_v_in[j]   = sq_src_v[j];
            sq_res_in[j] = sq_src_res[j] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int j = 0; j < SQ_STEPS; j++) begin
            sq_v_ff[j]    <= sq_v_in[j];
            sq_res_ff[j]  <= sq_res_in[j];
            sq_side_ff[j] <= sq_src_side[j];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Blend products. The exact centre gives h of one and is dropped here.
   // ------------------------------------------------------------------------
   logic [16:0]  bl_h, bl_inv;
   side_type     bl_side_in, bl_side_ff;
   logic [24:0]  bl_rim_in  [0:2];
   logic [24:0]  bl_core_in [0:2];
   logic [24:0]  bl_rim_ff  [0:2];
   logic [24:0]  bl_core_ff [0:2];
   logic         bl_valid_ff;

   always_comb begin
      bl_h   = sq_res_ff[SQ_STEPS-1][16:0];
      bl_inv = H_ONE - bl_h;
      bl_side_in      = sq_side_ff[SQ_STEPS-1];
      bl_side_in.live = sq_side_ff[SQ_STEPS-1].live
                        && (sq_res_ff[SQ_STEPS-1] < 34'(H_ONE));
      for (int c = 0; c < 3; c++) begin
         bl_rim_in[c]  = 25'(sq_side_ff[SQ_STEPS-1].rim[COLOR_W*(2-c) +: COLOR_W])
                         * 25'(bl_inv);
         bl_core_in[c] = 25'(sq_side_ff[SQ_STEPS-1].core[COLOR_W*(2-c) +: COLOR_W])
                         * 25'(bl_h);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         bl_side_ff <= bl_side_in;
         for (int c = 0; c < 3; c++) begin
            bl_rim_ff[c]  <= bl_rim_in[c];
            bl_core_ff[c] <= bl_core_in[c];
         end
      end
   end

   // Final sum and zeroing of rejected pixels.
   result_type last_result;

   always_comb begin
      logic [25:0] sum [0:2];
      for (int c = 0; c < 3; c++) begin
         sum[c] = 26'(bl_rim_ff[c]) + 26'(bl_core_ff[c]);
      end
      last_result.write_enable = bl_side_ff.live;
      last_result.pixel_index  = bl_side_ff.live ? bl_side_ff.index : '0;
      last_result.red          = bl_side_ff.live ? sum[0][23:16] : '0;
      last_result.green        = bl_side_ff.live ? sum[1][23:16] : '0;
      last_result.blue         = bl_side_ff.live ? sum[2][23:16] : '0;
   end

   // ------------------------------------------------------------------------
   // Valid bits travel with the data and are the only pipeline state cleared
   // by reset.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            div_valid_ff[k] <= 1'b0;
         end
         for (int j = 0; j < SQ_STEPS; j++) begin
            sq_valid_ff[j] <= 1'b0;
         end
         bl_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
         div_valid_ff[0] <= s8_valid_ff;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            div_valid_ff[k] <= div_valid_ff[k-1];
         end
         sq_valid_ff[0] <= div_valid_ff[DIV_STEPS];
         for (int j = 1; j < SQ_STEPS; j++) begin
            sq_valid_ff[j] <= sq_valid_ff[j-1];
         end
         bl_valid_ff <= sq_valid_ff[SQ_STEPS-1];
      end
   end

   // ------------------------------------------------------------------------
   // Output register with a one-entry skid buffer. While the skid entry is
   // empty the pipeline advances and its last stage lands either in the
   // output register (if that is free or being taken) or in the skid entry.
   // ------------------------------------------------------------------------
   result_type out_ff, skid_ff;
   logic       out_take;

   assign out_take = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_ff <= bl_valid_ff;
      end else if (bl_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (!out_valid_ff || out_take) begin
         out_ff <= last_result;
      end else begin
         skid_ff <= last_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_write_enable = out_ff.write_enable;
   assign rsp_pixel_index  = out_ff.pixel_index;
   assign rsp_out_red      = out_ff.red;
   assign rsp_out_green    = out_ff.green;
   assign rsp_out_blue     = out_ff.blue;

endmodule
